[src/pwmd_pkg.sv]
`timescale 1ns / 1ps

package pwmd_pkg;

   // Widths fixed by the interface.
   localparam int TIME_W   = 16;
   localparam int CSR_IW   = 3;
   localparam int CSR_DW   = 16;
   localparam int DUTY_W   = 11;

   // Configuration register indexes.
   localparam logic [CSR_IW-1:0] REG_ACTIVE_LOW   = 3'd0;
   localparam logic [CSR_IW-1:0] REG_DIR_INVERT   = 3'd1;
   localparam logic [CSR_IW-1:0] REG_MIN_DUTY     = 3'd2;
   localparam logic [CSR_IW-1:0] REG_RAMP_STEP    = 3'd3;
   localparam logic [CSR_IW-1:0] REG_SIG_TIMEOUT  = 3'd4;
   localparam logic [CSR_IW-1:0] REG_RETRY_DELAY  = 3'd5;
   localparam logic [CSR_IW-1:0] REG_RETRY_MAX    = 3'd6;
   localparam logic [CSR_IW-1:0] REG_COAST_MS     = 3'd7;

   // Request command codes.
   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Motor state codes.
   localparam logic [1:0] MS_IDLE  = 2'd0;
   localparam logic [1:0] MS_RUN   = 2'd1;
   localparam logic [1:0] MS_FAULT = 2'd2;

   // Drive direction codes.
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_FWD  = 2'd1;
   localparam logic [1:0] DIR_REV  = 2'd2;

   // Consecutive good periods needed before the measurement is trusted.
   localparam logic [1:0] VALID_NEED = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic pre;
      logic mul;
      logic div_start;
      logic fin;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
      logic div_busy;
      logic out_free;
   } ctl_sts_type;

endpackage

[src/pwmd_div.sv]
`timescale 1ns / 1ps

module pwmd_div #(
   parameter int DIVIDEND_W = 26
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DIVIDEND_W-1:0]         dividend,
   input  logic [pwmd_pkg::TIME_W-1:0]   divisor,
   output logic                          busy,
   output logic [DIVIDEND_W-1:0]         quotient
);
   import pwmd_pkg::*;

   localparam int CW = $clog2(DIVIDEND_W + 1);

   logic [TIME_W-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [TIME_W-1:0]     dsr_ff, dsr_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;

   logic [TIME_W:0]       shifted;
   logic [TIME_W:0]       diff;
   logic                  fits;

   // One restoring step: bring down the next dividend bit and try the subtract.
   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = (shifted >= {1'b0, dsr_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CW'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control state is reset; the operands need none.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[src/pwmd_ctrl.sv]
`timescale 1ns / 1ps

module pwmd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output pwmd_pkg::ctl_cmd_type  cmd,
   input  pwmd_pkg::ctl_sts_type  sts
);
   import pwmd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PRE  = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DST  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0] state_ff, state_in;

   // Sequence one request through prologue, optional multiply and divide, and commit.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            cmd.pre  = 1'b1;
            state_in = sts.need_div ? S_MUL : S_FIN;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DST;
         end
         S_DST: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (!sts.div_busy) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.fin  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/pwmd_dp.sv]
`timescale 1ns / 1ps

module pwmd_dp #(
   parameter int DUTY_MAX   = 1023,
   parameter int DC_HOLD_MS = 50
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pwmd_pkg::CSR_IW-1:0]         csr_index,
   input  logic [pwmd_pkg::CSR_DW-1:0]         csr_wdata,
   input  logic                                req_command,
   input  logic [pwmd_pkg::TIME_W-1:0]         req_capture_time,
   input  logic                                req_pin_level,
   input  logic                                req_dir_level,
   input  logic [1:0]                          req_motor_state,
   input  logic                                req_host_enumerated,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_duty_valid,
   output logic signed [pwmd_pkg::DUTY_W-1:0]  rsp_duty,
   output logic                                rsp_start_motor,
   output logic                                rsp_stop_motor,
   output logic                                rsp_clear_fault,
   output logic                                rsp_locked_out,
   input  pwmd_pkg::ctl_cmd_type               cmd,
   output pwmd_pkg::ctl_sts_type               sts
);
   import pwmd_pkg::*;

   localparam int DW = $clog2(DUTY_MAX + 1);
   localparam int HW = $clog2(DC_HOLD_MS + 1);
   localparam int PW = TIME_W + DW;
   localparam int SW = ((DW > 10) ? DW : 10) + 1;
   localparam int XW = ((DW + 1) > DUTY_W) ? (DW + 1) : DUTY_W;

   // Configuration registers.
   logic              active_low_ff;
   logic              dir_invert_ff;
   logic [9:0]        min_duty_ff;
   logic [9:0]        ramp_step_ff;
   logic [7:0]        sig_timeout_ff;
   logic [15:0]       retry_delay_ff;
   logic [7:0]        retry_max_ff;
   logic [15:0]       coast_ms_ff;

   // Latched request.
   logic              cmd_ff;
   logic [TIME_W-1:0] time_ff;
   logic              pin_ff;
   logic              dirl_ff;
   logic [1:0]        ms_ff;
   logic              host_ff;

   // Block state.
   logic              lockout_ff, lockout_in;
   logic [TIME_W-1:0] last_rise_ff, last_rise_in;
   logic              rise_seen_ff, rise_seen_in;
   logic [1:0]        valid_cnt_ff, valid_cnt_in;
   logic [7:0]        sig_timer_ff, sig_timer_in;
   logic [TIME_W-1:0] high_ff, high_in;
   logic [TIME_W-1:0] period_ff, period_in;
   logic [HW-1:0]     hold_ff, hold_in;
   logic [DW-1:0]     applied_ff, applied_in;
   logic [1:0]        drive_dir_ff, drive_dir_in;
   logic [15:0]       coast_ff, coast_in;
   logic [7:0]        retry_cnt_ff, retry_cnt_in;
   logic [15:0]       retry_tmr_ff, retry_tmr_in;

   // Product and result registers.
   logic [PW-1:0]     prod_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              o_dv_ff, o_dv_in;
   logic [DUTY_W-1:0] o_duty_ff, o_duty_in;
   logic              o_start_ff, o_start_in;
   logic              o_stop_ff, o_stop_in;
   logic              o_clear_ff, o_clear_in;
   logic              o_lock_ff, o_lock_in;

   // Working signals.
   logic              act;
   logic              is_tick;
   logic [HW-1:0]     hold_nx;
   logic [7:0]        timer_nx;
   logic [TIME_W-1:0] pulse;
   logic [TIME_W-1:0] per;
   logic [PW-1:0]     quo;
   logic              div_busy;
   logic              hold_full;
   logic              meas_bad;
   logic              q_low;
   logic [DW-1:0]     desired;
   logic [SW-1:0]     ramp_sum;
   logic [DW-1:0]     ramped;
   logic              out_free;
   logic              do_release;
   logic              do_stop;
   logic [1:0]        stop_ms;
   logic [1:0]        ms_eff;
   logic              go_on;
   logic [1:0]        reqdir;
   logic [DW-1:0]     app_new;
   logic [XW-1:0]     mag;
   logic [XW-1:0]     neg;

   // Tick prologue: DC-high hold count and signal timeout countdown.
   assign act     = pin_ff ^ active_low_ff;
   assign is_tick = !lockout_ff && !host_ff && (cmd_ff == CMD_TICK);
   assign hold_nx = !act ? '0 :
                    (hold_ff < HW'(DC_HOLD_MS)) ? hold_ff + 1'b1 : hold_ff;
   assign timer_nx = (sig_timer_ff != '0) ? sig_timer_ff - 1'b1 : sig_timer_ff;

   // A quotient is needed only for a trusted measurement without a DC hold.
   assign sts.need_div = is_tick && (hold_nx < HW'(DC_HOLD_MS)) && (timer_nx != '0) &&
                         (valid_cnt_ff == VALID_NEED) && (period_ff != '0);

   // Pulse width times full scale, then divided by the period.
   assign pulse = active_low_ff ? (period_ff - high_ff) : high_ff;
   assign per   = time_ff - last_rise_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= PW'(pulse) * PW'(DUTY_MAX);
      end
   end

   pwmd_div #(
      .DIVIDEND_W (PW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (period_ff),
      .busy     (div_busy),
      .quotient (quo)
   );

   assign sts.div_busy = div_busy;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign sts.out_free = out_free;

   // Target duty and the ramp toward it.
   assign hold_full = (hold_ff >= HW'(DC_HOLD_MS));
   assign meas_bad  = !hold_full && ((sig_timer_ff == '0) || (valid_cnt_ff != VALID_NEED) ||
                                     (period_ff == '0));
   assign q_low     = (quo <= PW'(min_duty_ff));
   assign desired   = (hold_full || (quo > PW'(DUTY_MAX))) ? DW'(DUTY_MAX) : quo[DW-1:0];
   assign ramp_sum  = SW'(applied_ff) + SW'(ramp_step_ff);
   assign ramped    = (applied_ff >= desired) ? desired :
                      (ramp_sum > SW'(desired)) ? desired : ramp_sum[DW-1:0];
   assign reqdir    = (dirl_ff ^ dir_invert_ff) ? DIR_FWD : DIR_REV;

   // Next state of the block and the result of the request.
   always_comb begin
      lockout_in   = lockout_ff;
      last_rise_in = last_rise_ff;
      rise_seen_in = rise_seen_ff;
      valid_cnt_in = valid_cnt_ff;
      sig_timer_in = sig_timer_ff;
      high_in      = high_ff;
      period_in    = period_ff;
      hold_in      = hold_ff;
      applied_in   = applied_ff;
      drive_dir_in = drive_dir_ff;
      coast_in     = coast_ff;
      retry_cnt_in = retry_cnt_ff;
      retry_tmr_in = retry_tmr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      o_dv_in      = o_dv_ff;
      o_duty_in    = o_duty_ff;
      o_start_in   = o_start_ff;
      o_stop_in    = o_stop_ff;
      o_clear_in   = o_clear_ff;
      o_lock_in    = o_lock_ff;
      do_release   = 1'b0;
      do_stop      = 1'b0;
      stop_ms      = ms_ff;
      ms_eff       = ms_ff;
      go_on        = 1'b0;
      app_new      = ramped;
      mag          = '0;
      neg          = '0;

      if (cmd.pre && is_tick) begin
         hold_in      = hold_nx;
         sig_timer_in = timer_nx;
      end

      if (cmd.fin) begin
         rsp_valid_in = 1'b1;
         o_dv_in      = 1'b0;
         o_duty_in    = '0;
         o_start_in   = 1'b0;
         o_stop_in    = 1'b0;
         o_clear_in   = 1'b0;

         if (lockout_ff) begin
            // Locked out: nothing but the lock flag.
         end else if (host_ff) begin
            lockout_in = 1'b1;
            do_release = 1'b1;
         end else if (cmd_ff == CMD_EDGE) begin
            // Capture edge: rising edges measure the period, falling the high time.
            sig_timer_in = sig_timeout_ff;
            if (pin_ff) begin
               if (rise_seen_ff) begin
                  if ((per != '0) && (high_ff < per)) begin
                     period_in = per;
                     if (valid_cnt_ff < VALID_NEED) begin
                        valid_cnt_in = valid_cnt_ff + 1'b1;
                     end
                  end else begin
                     valid_cnt_in = '0;
                  end
               end
               last_rise_in = time_ff;
               rise_seen_in = 1'b1;
            end else if (rise_seen_ff) begin
               high_in = per;
            end
         end else if (meas_bad) begin
            // Signal lost or untrusted: hold the drive off, release if the pin is idle.
            if (act) begin
               do_stop = 1'b1;
            end else begin
               do_release = 1'b1;
            end
         end else if (!hold_full && q_low) begin
            do_release = 1'b1;
         end else begin
            go_on = 1'b1;
            if (ms_ff == MS_FAULT) begin
               // Fault recovery: wait out the delay, then clear a limited number of times.
               if (retry_tmr_ff != '0) begin
                  retry_tmr_in = retry_tmr_ff - 1'b1;
                  go_on        = 1'b0;
               end else if (retry_cnt_ff >= retry_max_ff) begin
                  go_on = 1'b0;
               end else begin
                  app_new      = '0;
                  o_clear_in   = 1'b1;
                  retry_cnt_in = retry_cnt_ff + 1'b1;
                  retry_tmr_in = retry_delay_ff;
                  ms_eff       = MS_IDLE;
               end
            end
            applied_in = app_new;
            stop_ms    = ms_eff;
            if (go_on) begin
               // Coast on a reversal, otherwise issue the signed duty.
               if (coast_ff != '0) begin
                  coast_in = coast_ff - 1'b1;
                  do_stop  = 1'b1;
               end else if ((app_new != '0) && (drive_dir_ff != DIR_NONE) &&
                            (reqdir != drive_dir_ff)) begin
                  coast_in = coast_ms_ff;
                  do_stop  = 1'b1;
               end else begin
                  mag          = XW'(app_new);
                  neg          = '0 - mag;
                  o_dv_in      = 1'b1;
                  o_duty_in    = (reqdir == DIR_FWD) ? mag[DUTY_W-1:0] : neg[DUTY_W-1:0];
                  o_start_in   = (ms_eff == MS_IDLE);
                  drive_dir_in = reqdir;
               end
            end
         end

         // Release clears the measurement and recovery state, then stops.
         if (do_release) begin
            last_rise_in = '0;
            rise_seen_in = 1'b0;
            valid_cnt_in = '0;
            sig_timer_in = '0;
            hold_in      = '0;
            retry_cnt_in = '0;
            retry_tmr_in = '0;
            coast_in     = '0;
            high_in      = '0;
            period_in    = '0;
            do_stop      = 1'b1;
         end

         // Stop motion: zero the drive and issue a zero duty.
         if (do_stop) begin
            applied_in   = '0;
            drive_dir_in = DIR_NONE;
            o_dv_in      = 1'b1;
            o_duty_in    = '0;
            o_stop_in    = (stop_ms == MS_RUN);
         end

         o_lock_in = lockout_in;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_low_ff  <= 1'b0;
         dir_invert_ff  <= 1'b0;
         min_duty_ff    <= 10'd20;
         ramp_step_ff   <= 10'd5;
         sig_timeout_ff <= 8'd50;
         retry_delay_ff <= 16'd500;
         retry_max_ff   <= 8'd3;
         coast_ms_ff    <= 16'd200;
      end else if (csr_we) begin
         case (csr_index)
            REG_ACTIVE_LOW:  active_low_ff  <= csr_wdata[0];
            REG_DIR_INVERT:  dir_invert_ff  <= csr_wdata[0];
            REG_MIN_DUTY:    min_duty_ff    <= csr_wdata[9:0];
            REG_RAMP_STEP:   ramp_step_ff   <= csr_wdata[9:0];
            REG_SIG_TIMEOUT: sig_timeout_ff <= csr_wdata[7:0];
            REG_RETRY_DELAY: retry_delay_ff <= csr_wdata[15:0];
            REG_RETRY_MAX:   retry_max_ff   <= csr_wdata[7:0];
            REG_COAST_MS:    coast_ms_ff    <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Request latch.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_command;
         time_ff <= req_capture_time;
         pin_ff  <= req_pin_level;
         dirl_ff <= req_dir_level;
         ms_ff   <= req_motor_state;
         host_ff <= req_host_enumerated;
      end
   end

   // Block state and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff   <= 1'b0;
         last_rise_ff <= '0;
         rise_seen_ff <= 1'b0;
         valid_cnt_ff <= '0;
         sig_timer_ff <= '0;
         high_ff      <= '0;
         period_ff    <= '0;
         hold_ff      <= '0;
         applied_ff   <= '0;
         drive_dir_ff <= DIR_NONE;
         coast_ff     <= '0;
         retry_cnt_ff <= '0;
         retry_tmr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lockout_ff   <= lockout_in;
         last_rise_ff <= last_rise_in;
         rise_seen_ff <= rise_seen_in;
         valid_cnt_ff <= valid_cnt_in;
         sig_timer_ff <= sig_timer_in;
         high_ff      <= high_in;
         period_ff    <= period_in;
         hold_ff      <= hold_in;
         applied_ff   <= applied_in;
         drive_dir_ff <= drive_dir_in;
         coast_ff     <= coast_in;
         retry_cnt_ff <= retry_cnt_in;
         retry_tmr_ff <= retry_tmr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      o_dv_ff    <= o_dv_in;
      o_duty_ff  <= o_duty_in;
      o_start_ff <= o_start_in;
      o_stop_ff  <= o_stop_in;
      o_clear_ff <= o_clear_in;
      o_lock_ff  <= o_lock_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_duty_valid  = o_dv_ff;
   assign rsp_duty        = $signed(o_duty_ff);
   assign rsp_start_motor = o_start_ff;
   assign rsp_stop_motor  = o_stop_ff;
   assign rsp_clear_fault = o_clear_ff;
   assign rsp_locked_out  = o_lock_ff;

`ifndef ASSERT_OFF
   a_lock_sticky: assert property (@(posedge clock) disable iff (reset)
      lockout_ff |=> lockout_ff)
      else $error("lockout flag dropped without reset");

   a_duty_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_duty != '0)) |-> rsp_duty_valid)
      else $error("nonzero duty without duty_valid");

   a_start_stop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_start_motor && rsp_stop_motor))
      else $error("start and stop requested together");

   a_valid_cnt_sat: assert property (@(posedge clock) disable iff (reset)
      valid_cnt_ff <= VALID_NEED)
      else $error("valid count above saturation");

   a_applied_range: assert property (@(posedge clock) disable iff (reset)
      applied_ff <= DW'(DUTY_MAX))
      else $error("applied duty above full scale");
`endif

endmodule

[src/pwm_input_to_motor_duty.sv]
`timescale 1ns / 1ps
// Sequence: a request accepted in IDLE is latched and passes PRE; edge, lockout and
// non-dividing tick requests then go to FIN, while ticks that compute a duty pass
// MUL, DST and DIV first, the restoring divider yielding one quotient bit per cycle.
// FIN loads the result register once the output is free. One request at a time: the
// next is accepted after the result is loaded; a waiting result does not block it.
// Reset is synchronous and active high: control and block state clear, CSRs default.

module pwm_input_to_motor_duty #(
   parameter int DUTY_MAX   = 1023,
   parameter int DC_HOLD_MS = 50
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pwmd_pkg::CSR_IW-1:0]         csr_index,
   input  logic [pwmd_pkg::CSR_DW-1:0]         csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [pwmd_pkg::TIME_W-1:0]         req_capture_time,
   input  logic                                req_pin_level,
   input  logic                                req_dir_level,
   input  logic [1:0]                          req_motor_state,
   input  logic                                req_host_enumerated,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_duty_valid,
   output logic signed [pwmd_pkg::DUTY_W-1:0]  rsp_duty,
   output logic                                rsp_start_motor,
   output logic                                rsp_stop_motor,
   output logic                                rsp_clear_fault,
   output logic                                rsp_locked_out
);
   import pwmd_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // Sequencer.
   pwmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Measurement, duty computation and result register.
   pwmd_dp #(
      .DUTY_MAX   (DUTY_MAX),
      .DC_HOLD_MS (DC_HOLD_MS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_command         (req_command),
      .req_capture_time    (req_capture_time),
      .req_pin_level       (req_pin_level),
      .req_dir_level       (req_dir_level),
      .req_motor_state     (req_motor_state),
      .req_host_enumerated (req_host_enumerated),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_duty_valid      (rsp_duty_valid),
      .rsp_duty            (rsp_duty),
      .rsp_start_motor     (rsp_start_motor),
      .rsp_stop_motor      (rsp_stop_motor),
      .rsp_clear_fault     (rsp_clear_fault),
      .rsp_locked_out      (rsp_locked_out),
      .cmd                 (cmd),
      .sts                 (sts)
   );

endmodule
